[hw/rtl/crtac_pkg.sv]
`timescale 1ns / 1ps

package crtac_pkg;

	// source pair codes, bit 1 is the left source pixel
	typedef logic [1:0] pair_t;

	localparam pair_t PAIR_DARK   = 2'b00;
	localparam pair_t PAIR_LOW    = 2'b01;
	localparam pair_t PAIR_HIGH   = 2'b10;
	localparam pair_t PAIR_BRIGHT = 2'b11;

	// rgb565 colors
	localparam int PixelWidth = 16;

	typedef logic [PixelWidth-1:0] pixel_t;

	localparam pixel_t COLOR_BLACK  = 16'h0000;
	localparam pixel_t COLOR_BLUE   = 16'h001F;
	localparam pixel_t COLOR_ORANGE = 16'hFC80;
	localparam pixel_t COLOR_WHITE  = 16'hFFFF;

	// result queue sizing
	localparam int FifoDepth = 4;
	localparam int PtrWidth  = $clog2(FifoDepth);
	localparam int CntWidth  = $clog2(FifoDepth + 1);

	// one output item
	typedef struct packed {
		pixel_t left_pixel;
		pixel_t right_pixel;
		logic   row_last;
	} result_t;

	// results made by one accepted item, packed low first
	typedef struct packed {
		logic    first_valid;
		logic    second_valid;
		result_t first;
		result_t second;
	} render_t;

	// colors of one pair from its neighbors; rules follow the codes, not the colors
	function automatic result_t render_pair(pair_t cur, pair_t prev, pair_t next,
		logic swap, logic last);
		pixel_t  c_low;
		pixel_t  c_high;
		result_t res;
		c_low  = swap ? COLOR_ORANGE : COLOR_BLUE;
		c_high = swap ? COLOR_BLUE : COLOR_ORANGE;
		res.row_last = last;
		case (cur)
			PAIR_LOW: begin
				if (next == PAIR_HIGH || next == PAIR_BRIGHT) begin
					res.left_pixel  = COLOR_BLACK;
					res.right_pixel = COLOR_WHITE;
				end else begin
					res.left_pixel  = c_low;
					res.right_pixel = c_low;
				end
			end
			PAIR_HIGH: begin
				if (prev == PAIR_LOW || prev == PAIR_BRIGHT) begin
					res.left_pixel  = COLOR_WHITE;
					res.right_pixel = COLOR_BLACK;
				end else begin
					res.left_pixel  = c_high;
					res.right_pixel = c_high;
				end
			end
			PAIR_BRIGHT: begin
				res.left_pixel  = COLOR_WHITE;
				res.right_pixel = COLOR_WHITE;
			end
			default: begin
				res.left_pixel  = COLOR_BLACK;
				res.right_pixel = COLOR_BLACK;
			end
		endcase
		return res;
	endfunction

endpackage

[hw/rtl/crt_artifact_color_pairs.sv]
`timescale 1ns / 1ps

// Artifact-color renderer for a 1bpp scanline: each two-bit source pair
// becomes two rgb565 pixels (left_pixel, right_pixel).
// Channels:
//   cfg  - cfg_valid/cfg_ready/cfg_data writes swap_colors; always ready.
//          Write only while no results are outstanding.
//   in   - in_valid/in_ready with bit_pair and row_end (last pair of a row).
//   out  - out_valid/out_ready with left_pixel, right_pixel, row_last.
// Order: a pair's result is drawn when its right neighbor is accepted and
// is registered into the output queue; a pair carrying row_end is drawn at
// once, so that item yields two results when a pair was waiting, one
// otherwise. The first pair of a row that is longer than one pair yields none.
// Throughput: one item per cycle while in_ready is high; a row end puts up
// to two results into a four-entry output queue that drains one per cycle
// while out_ready is high, so in_ready drops only when over two are queued.
// Stall: while out_ready is low the head item holds and the queue fills;
// in_ready falls before it can overflow.
// Reset: arst_n clears the queue, the neighbor state (black left edge,
// nothing pending) and swap_colors.
module crt_artifact_color_pairs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           bit_pair,
	input  logic                 row_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          left_pixel,
	output logic [15:0]          right_pixel,
	output logic                 row_last
);
	import crtac_pkg::*;

	logic    swap_colors_q;
	logic    accept;
	logic    room;
	render_t render;
	result_t head;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_colors_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			swap_colors_q <= cfg_data;
		end
	end

	// input handshake
	assign in_ready = room;
	assign accept   = in_valid && in_ready;

	crtac_pair_render u_render (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.bit_pair    (bit_pair),
		.row_end     (row_end),
		.swap_colors (swap_colors_q),
		.render      (render)
	);

	crtac_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (render),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// output fields
	assign left_pixel  = head.left_pixel;
	assign right_pixel = head.right_pixel;
	assign row_last    = head.row_last;

endmodule

[hw/rtl/crtac_pair_render.sv]
`timescale 1ns / 1ps

module crtac_pair_render (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  crtac_pkg::pair_t  bit_pair,
	input  logic              row_end,
	input  logic              swap_colors,
	output crtac_pkg::render_t render
);
	import crtac_pkg::*;

	pair_t   pending_pair_q;
	logic    pending_valid_q;
	pair_t   previous_pair_q;
	pair_t   flush_prev;
	logic    emit_pending;
	logic    emit_flush;
	result_t pending_res;
	result_t flush_res;

	// pending pair is drawn once its right neighbor shows up
	assign emit_pending = accept && pending_valid_q;
	assign emit_flush   = accept && row_end;
	assign pending_res  = render_pair(pending_pair_q, previous_pair_q, bit_pair,
		swap_colors, 1'b0);

	// row end draws the incoming pair at once with a black right edge
	assign flush_prev = pending_valid_q ? pending_pair_q : previous_pair_q;
	assign flush_res  = render_pair(bit_pair, flush_prev, PAIR_DARK, swap_colors, 1'b1);

	// pack results low first
	always_comb begin
		render.first_valid  = emit_pending || emit_flush;
		render.second_valid = emit_pending && emit_flush;
		render.first        = emit_pending ? pending_res : flush_res;
		render.second       = flush_res;
	end

	// neighbor tracking across the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_pair_q  <= PAIR_DARK;
			pending_valid_q <= 1'b0;
			previous_pair_q <= PAIR_DARK;
		end else if (accept) begin
			if (row_end) begin
				pending_pair_q  <= PAIR_DARK;
				pending_valid_q <= 1'b0;
				previous_pair_q <= PAIR_DARK;
			end else begin
				if (pending_valid_q) begin
					previous_pair_q <= pending_pair_q;
				end
				pending_pair_q  <= bit_pair;
				pending_valid_q <= 1'b1;
			end
		end
	end

endmodule

[hw/rtl/crtac_result_fifo.sv]
`timescale 1ns / 1ps

module crtac_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  crtac_pkg::render_t push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output crtac_pkg::result_t head
);
	import crtac_pkg::*;

	result_t               mem_q [FifoDepth];
	logic [PtrWidth-1:0]   wr_ptr_q;
	logic [PtrWidth-1:0]   rd_ptr_q;
	logic [CntWidth-1:0]   count_q;
	logic [PtrWidth-1:0]   wr_ptr_p1;
	logic [PtrWidth-1:0]   wr_step;
	logic [CntWidth-1:0]   push_n;
	logic                  pop;

	// status and head item
	assign out_valid = (count_q != '0);
	assign room      = (count_q <= CntWidth'(FifoDepth - 2));
	assign head      = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	assign wr_ptr_p1 = wr_ptr_q + PtrWidth'(1);
	assign push_n    = CntWidth'(push.first_valid) + CntWidth'(push.second_valid);
	assign wr_step   = PtrWidth'(push_n);

	// item storage, up to two writes per cycle
	always_ff @(posedge clk) begin
		if (push.first_valid) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.second_valid) begin
			mem_q[wr_ptr_p1] <= push.second;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + wr_step;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrWidth'(1);
			end
			count_q <= count_q + push_n - CntWidth'(pop);
		end
	end

endmodule

[hw/rtl/crtac_checker.sv]
`timescale 1ns / 1ps

module crtac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        row_end,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] left_pixel,
	input logic [15:0] right_pixel,
	input logic        row_last
);
	import crtac_pkg::*;

	// a stalled item holds its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_pixel)
			&& $stable(right_pixel) && $stable(row_last))
		else $error("stalled output item changed");

	// a row end always leaves a result ready on the next cycle
	a_row_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && row_end |=> out_valid)
		else $error("row end gave no result");

	// split pixels only come from the neighbor rules
	a_split_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (left_pixel != right_pixel) |->
			(left_pixel == COLOR_BLACK && right_pixel == COLOR_WHITE)
			|| (left_pixel == COLOR_WHITE && right_pixel == COLOR_BLACK))
		else $error("unexpected split pixel colors");

	// black,white needs a high or bright right neighbor, so never ends a row
	a_no_last_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && left_pixel == COLOR_BLACK && right_pixel == COLOR_WHITE |->
			!row_last)
		else $error("black,white item at row end");

endmodule

bind crt_artifact_color_pairs crtac_checker u_crtac_checker (.*);
